// ----- rtl/nfcsb_pkg.sv -----
// Shared types and constants for the no-four-coplanar set builder.
`default_nettype none
package nfcsb_pkg;
	localparam int CoordW = 4;
	localparam int PointW = 3 * CoordW;
	localparam int StatusW = 3;
	localparam int CountW = 7;
	localparam int DetW = 16;

	typedef enum logic [StatusW-1:0] {
		ST_ADDED     = 3'd0,
		ST_COPLANAR  = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_CLEARED   = 3'd4
	} status_t;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DUP   = 7'b0000010,
		S_WAIT  = 7'b0000100,
		S_TRI   = 7'b0001000,
		S_CALC  = 7'b0010000,
		S_ADD   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // capture candidate, clear indices
		logic clear;     // empty the set
		logic dup_step;  // read next entry for duplicate scan
		logic tri_step;  // advance triple indices and read
		logic append;    // write candidate at count
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic dup_done;
		logic dup_hit;
		logic full;
		logic tri_done;
		logic det_zero;
	} sts_t;
endpackage
`default_nettype wire

// ----- rtl/nfcsb_datapath.sv -----
// Point store, triple sweep indices and determinant unit.
`default_nettype none
module nfcsb_datapath import nfcsb_pkg::*; #(
	parameter int MaxPoints = 64,
	parameter int IdxW = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic [PointW-1:0] cand_in,
	output sts_t sts,
	output logic [IdxW:0] count
);
	logic [PointW-1:0] mem_a [MaxPoints];
	logic [PointW-1:0] mem_b [MaxPoints];
	logic [PointW-1:0] mem_c [MaxPoints];
	logic [PointW-1:0] cand_q, pa_q, pb_q, pc_q;
	logic [IdxW:0] count_q, i_q, j_q, l_q, dcnt_q;
	logic dup_q, rd_v_q, tri_v_q, det_zero_q, det_v_q;
	logic signed [DetW-1:0] m1_q, m2_q, m3_q, ux_q, uy_q, uz_q;
	logic dup_rd, tri_rd;

	assign count = count_q;

	// read only stored entries; fewer than three points leave no triple to test
	assign dup_rd = cmd.dup_step && (dcnt_q < count_q);
	assign tri_rd = cmd.tri_step && (count_q >= (IdxW+1)'(3));

	// three copies of the store give three read ports
	always_ff @(posedge clk) begin
		if (cmd.append) begin
			mem_a[count_q[IdxW-1:0]] <= cand_q;
			mem_b[count_q[IdxW-1:0]] <= cand_q;
			mem_c[count_q[IdxW-1:0]] <= cand_q;
		end
		pa_q <= mem_a[dup_rd ? dcnt_q[IdxW-1:0] : i_q[IdxW-1:0]];
		pb_q <= mem_b[j_q[IdxW-1:0]];
		pc_q <= mem_c[l_q[IdxW-1:0]];
	end

	function automatic logic signed [DetW-1:0] dif(input logic [PointW-1:0] p,
			input logic [PointW-1:0] c, input int ax);
		logic [CoordW-1:0] a, b;
		a = p[PointW-1-CoordW*ax -: CoordW];
		b = c[PointW-1-CoordW*ax -: CoordW];
		return DetW'($signed({1'b0, a})) - DetW'($signed({1'b0, b}));
	endfunction

	logic signed [DetW-1:0] vx, vy, vz, wx, wy, wz, det;
	always_comb begin
		vx = dif(pb_q, cand_q, 0); vy = dif(pb_q, cand_q, 1); vz = dif(pb_q, cand_q, 2);
		wx = dif(pc_q, cand_q, 0); wy = dif(pc_q, cand_q, 1); wz = dif(pc_q, cand_q, 2);
		det = ux_q * m1_q - uy_q * m2_q + uz_q * m3_q;
	end

	// triple index sweep: i<j<l<count
	logic last_tri;
	assign last_tri = (l_q + 1'b1 >= count_q) && (j_q + 2'd2 >= count_q)
		&& (i_q + 2'd3 >= count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; i_q <= '0; j_q <= '0; l_q <= '0; dcnt_q <= '0;
			dup_q <= 1'b0; rd_v_q <= 1'b0; tri_v_q <= 1'b0;
			det_zero_q <= 1'b0; det_v_q <= 1'b0; cand_q <= '0;
		end else begin
			rd_v_q <= dup_rd;
			if (rd_v_q && pa_q == cand_q) dup_q <= 1'b1;
			tri_v_q <= tri_rd;
			det_v_q <= tri_v_q;
			if (det_v_q && det == '0) det_zero_q <= 1'b1;
			if (cmd.load) begin
				cand_q <= cand_in;
				i_q <= '0; j_q <= (IdxW+1)'(1); l_q <= (IdxW+1)'(2);
				dcnt_q <= '0; dup_q <= 1'b0; det_zero_q <= 1'b0;
			end
			if (cmd.clear) count_q <= '0;
			if (cmd.append) count_q <= count_q + 1'b1;
			if (dup_rd) dcnt_q <= dcnt_q + 1'b1;
			if (tri_rd) begin
				if (l_q + 1'b1 < count_q) l_q <= l_q + 1'b1;
				else if (j_q + 2'd2 < count_q) begin
					j_q <= j_q + 1'b1; l_q <= j_q + 2'd2;
				end else begin
					i_q <= i_q + 1'b1; j_q <= i_q + 2'd2; l_q <= i_q + 2'd3;
				end
			end
		end
	end

	// stage two: minors and first row
	always_ff @(posedge clk) begin
		m1_q <= vy * wz - vz * wy;
		m2_q <= vx * wz - vz * wx;
		m3_q <= vx * wy - vy * wx;
		ux_q <= dif(pa_q, cand_q, 0);
		uy_q <= dif(pa_q, cand_q, 1);
		uz_q <= dif(pa_q, cand_q, 2);
	end

	always_comb begin
		sts.dup_done = (dcnt_q >= count_q) && !rd_v_q;
		sts.dup_hit  = dup_q;
		sts.full     = count_q >= (IdxW+1)'(MaxPoints);
		sts.tri_done = last_tri || count_q < (IdxW+1)'(3);
		sts.det_zero = det_zero_q;
	end
endmodule
`default_nettype wire

// ----- rtl/nfcsb_ctrl.sv -----
// Controller state machine sequencing scans and the handshake.
`default_nettype none
module nfcsb_ctrl import nfcsb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_op,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	output status_t status,
	input  wire sts_t sts,
	output cmd_t cmd
);
	state_t state_q;
	status_t status_q;
	logic [1:0] drain_q;
	logic out_v_q;

	assign status = status_q;
	assign out_valid = out_v_q;
	assign in_ready = (state_q == S_IDLE) && (!out_v_q || out_ready);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: if (in_valid && in_ready) begin
				cmd.load = 1'b1;
				cmd.clear = !in_op;
			end
			S_DUP:  cmd.dup_step = !sts.dup_done;
			S_TRI:  cmd.tri_step = 1'b1;
			S_ADD:  cmd.append = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_v_q <= 1'b0; drain_q <= '0;
			status_q <= ST_ADDED;
		end else begin
			if (out_v_q && out_ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					if (!in_op) begin
						status_q <= ST_CLEARED; state_q <= S_OUT;
					end else state_q <= S_DUP;
				end
				S_DUP: if (sts.dup_done) begin
					if (sts.dup_hit) begin
						status_q <= ST_DUPLICATE; state_q <= S_OUT;
					end else if (sts.full) begin
						status_q <= ST_FULL; state_q <= S_OUT;
					end else if (sts.tri_done && !(sts.full)) begin
						// fewer than three points or single triple handled in sweep
						state_q <= S_TRI;
					end else state_q <= S_TRI;
				end
				S_TRI: if (sts.tri_done) begin
					drain_q <= 2'd3; state_q <= S_CALC;
				end
				S_CALC: begin
					drain_q <= drain_q - 1'b1;
					if (drain_q == 2'd0) begin
						if (sts.det_zero) begin
							status_q <= ST_COPLANAR; state_q <= S_OUT;
						end else begin
							status_q <= ST_ADDED; state_q <= S_ADD;
						end
					end
				end
				S_ADD: state_q <= S_OUT;
				S_OUT: begin
					out_v_q <= 1'b1; state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/no_four_coplanar_set_builder_unit.sv -----
// Top level of the no-four-coplanar set builder.
// One item at a time. A clear goes straight to S_OUT, which registers its
// result. A try-add first scans the stored points for a duplicate, one entry
// a cycle. It then tests one triple a cycle in a three-stage determinant
// pipe; a full store answers right after the duplicate scan. The next item is
// taken once the output register is empty or its result is accepted.
`default_nettype none
module no_four_coplanar_set_builder_unit import nfcsb_pkg::*; #(
	parameter int MaxPoints = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic s_tready,
	input  wire logic [15:0] s_tdata, // op, point_x, point_y, point_z
	output logic m_tvalid,
	input  wire logic m_tready,
	output logic [15:0] m_tdata  // status, set_count
);
	localparam int IdxW = $clog2(MaxPoints);
	cmd_t cmd;
	sts_t sts;
	status_t status;
	logic [IdxW:0] count;
	logic [PointW-1:0] cand;

	assign cand = {s_tdata[4:1], s_tdata[8:5], s_tdata[12:9]};

	nfcsb_ctrl u_ctrl (
		.clk, .arst_n, .in_valid(s_tvalid), .in_op(s_tdata[0]),
		.in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
		.status, .sts, .cmd
	);

	nfcsb_datapath #(.MaxPoints(MaxPoints), .IdxW(IdxW)) u_dp (
		.clk, .arst_n, .cmd, .cand_in(cand), .sts, .count
	);

	logic [CountW-1:0] cnt7;
	assign cnt7 = CountW'(count);
	assign m_tdata = {6'd0, cnt7, status};
endmodule
`default_nettype wire

// ----- bench/no_four_coplanar_set_builder_unit_tb.sv -----
// Self-checking bench for the no-four-coplanar set builder: directed and random items.
`default_nettype none
module no_four_coplanar_set_builder_unit_tb;
	import nfcsb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int StoreDepth = 64;
	localparam int StallLimit = 200000;

	// Keeps its own copy of the point set and the queue of expected results.
	class coplanar_set_scoreboard;
		logic [PointW-1:0] points[StoreDepth];
		int unsigned npoints;
		status_t want_status[$];
		logic [CountW-1:0] want_count[$];
		int unsigned mismatches;

		function new();
			npoints = 0;
			mismatches = 0;
		endfunction

		function logic in_one_plane(logic [PointW-1:0] c, logic [PointW-1:0] p,
				logic [PointW-1:0] q, logic [PointW-1:0] r);
			int ux, uy, uz, vx, vy, vz, wx, wy, wz, det;
			ux = int'(p[11:8]) - int'(c[11:8]);
			uy = int'(p[7:4]) - int'(c[7:4]);
			uz = int'(p[3:0]) - int'(c[3:0]);
			vx = int'(q[11:8]) - int'(c[11:8]);
			vy = int'(q[7:4]) - int'(c[7:4]);
			vz = int'(q[3:0]) - int'(c[3:0]);
			wx = int'(r[11:8]) - int'(c[11:8]);
			wy = int'(r[7:4]) - int'(c[7:4]);
			wz = int'(r[3:0]) - int'(c[3:0]);
			det = ux * (vy * wz - vz * wy) - uy * (vx * wz - vz * wx)
				+ uz * (vx * wy - vy * wx);
			return det == 0;
		endfunction

		function void note_item(logic op, logic [3:0] x, logic [3:0] y, logic [3:0] z);
			logic [PointW-1:0] cand;
			status_t st;
			logic dup, flat;
			cand = {x, y, z};
			dup = 0;
			flat = 0;
			if (!op) begin
				npoints = 0;
				st = ST_CLEARED;
			end else begin
				for (int i = 0; i < npoints; i++)
					if (points[i] == cand) dup = 1;
				if (dup) st = ST_DUPLICATE;
				else if (npoints >= StoreDepth) st = ST_FULL;
				else begin
					for (int i = 0; i < npoints; i++)
						for (int j = i + 1; j < npoints; j++)
							for (int l = j + 1; l < npoints; l++)
								if (!flat && in_one_plane(cand, points[i], points[j], points[l]))
									flat = 1;
					if (flat) st = ST_COPLANAR;
					else begin
						points[npoints] = cand;
						npoints++;
						st = ST_ADDED;
					end
				end
			end
			want_status.push_back(st);
			want_count.push_back(CountW'(npoints));
		endfunction

		function void check_result(logic [15:0] data);
			status_t st;
			logic [CountW-1:0] cnt;
			if (want_status.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", data);
				return;
			end
			st = want_status.pop_front();
			cnt = want_count.pop_front();
			if (data[2:0] !== st || data[9:3] !== cnt) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
						st, data[2:0], cnt, data[9:3]);
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [15:0] s_tdata = '0;  // op, point_x, point_y, point_z
	logic m_tvalid;
	logic m_tready = 0;
	logic [15:0] m_tdata;       // status, set_count

	coplanar_set_scoreboard sb = new();
	bit hold_now = 0;
	bit no_gaps = 0;
	int unsigned quiet_cycles = 0;

	no_four_coplanar_set_builder_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
		return $urandom_range(1, 3);
	endfunction

	task automatic send_item(logic op, logic [3:0] x, logic [3:0] y, logic [3:0] z);
		int unsigned gap;
		gap = (no_gaps || $urandom_range(0, 2) != 0) ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {3'b000, z, y, x, op};
		do @(posedge clk); while (!s_tready);
		sb.note_item(op, x, y, z);
	endtask

	task automatic add_point(logic [3:0] x, logic [3:0] y, logic [3:0] z);
		send_item(1'b1, x, y, z);
	endtask

	// receiver: random stalls, with a long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_now) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				hold_now = 0;
			end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 0;
				repeat (gap_len()) @(posedge clk);
			end else begin
				m_tready <= 1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) sb.check_result(m_tdata);
		if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("FAIL no_four_coplanar_set_builder_unit");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: clear with junk fields, corners, duplicate, collinear point
		send_item(1'b0, 4'hf, 4'ha, 4'h5);
		add_point(4'h0, 4'h0, 4'h0);
		add_point(4'hf, 4'hf, 4'hf);
		add_point(4'h0, 4'h0, 4'h0);
		add_point(4'hf, 4'h0, 4'h0);
		add_point(4'h1, 4'h1, 4'h1);
		add_point(4'h0, 4'hf, 4'h0);
		add_point(4'h0, 4'h0, 4'hf);
		add_point(4'hf, 4'hf, 4'h0);
		add_point(4'h5, 4'ha, 4'h3);
		add_point(4'hf, 4'hf, 4'hf);
		send_item(1'b0, 4'h0, 4'h0, 4'h0);
		add_point(4'ha, 4'h5, 4'hc);
		add_point(4'h3, 4'hc, 4'h9);

		// items sent during a long receiver hold-off, with the usual random gaps
		hold_now = 1;
		for (int i = 0; i < 5; i++) add_point(4'($urandom), 4'($urandom), 4'($urandom));

		// pause until drained
		s_tvalid <= 0;
		while (sb.want_status.size() != 0) @(posedge clk);
		@(posedge clk);

		for (int i = 0; i < 100; i++) begin
			no_gaps = (i >= 40 && i < 60);
			if ($urandom_range(0, 14) == 0)
				send_item(1'b0, 4'($urandom), 4'($urandom), 4'($urandom));
			else add_point(4'($urandom), 4'($urandom), 4'($urandom));
		end
		s_tvalid <= 0;
		no_gaps = 0;

		while (sb.want_status.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.mismatches == 0) $display("PASS no_four_coplanar_set_builder_unit");
		else $display("FAIL no_four_coplanar_set_builder_unit");
		$finish;
	end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/nfcsb_pkg.sv
rtl/nfcsb_datapath.sv
rtl/nfcsb_ctrl.sv
rtl/no_four_coplanar_set_builder_unit.sv
bench/no_four_coplanar_set_builder_unit_tb.sv
